// ===== sv/frc_pkg.sv =====
`timescale 1ns / 1ps

package frc_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_PUT    = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] write_value;
    } frc_in_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] read_value;
    } frc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_VALUE,
        ST_REPLY
    } frc_state_t;

endpackage

// ===== sv/frc_kv_mem.sv =====
`timescale 1ns / 1ps

module frc_kv_mem #(
    parameter int CAPACITY = frc_pkg::CAPACITY_DEF,
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                aclk,
    input  logic [SLOT_W-1:0]   key_raddr,
    output logic signed [31:0]  key_rdata,
    input  logic [SLOT_W-1:0]   value_raddr,
    output logic signed [31:0]  value_rdata,
    input  logic                key_we,
    input  logic                value_we,
    input  logic [SLOT_W-1:0]   waddr,
    input  logic signed [31:0]  key_wdata,
    input  logic signed [31:0]  value_wdata
);

    logic signed [31:0] key_mem [CAPACITY];
    logic signed [31:0] value_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[waddr] <= key_wdata;
        end
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (value_we) begin
            value_mem[waddr] <= value_wdata;
        end
        value_rdata <= value_mem[value_raddr];
    end

endmodule

// ===== sv/fifo_replacement_cache.sv =====
`timescale 1ns / 1ps
// Channel  Ports                      Payload    Carries
// -------  -------------------------  ---------  -------------------------------
// s_       s_valid s_ready s_data     frc_in_t   lookup or put request
// m_       m_valid m_ready m_data     frc_out_t  status and value, one per request
//
// One request at a time. Keys are read from a registered synchronous memory,
// one live slot per cycle from the oldest, so a request searches up to
// live_count slots (at most CAPACITY) before the next s_ready.
// Reset empties the ring (head, tail, count) at once; no memory clearing pass.
// A stalled m_ready holds the result; the next request is taken meanwhile and
// waits in the reply state only if its own result finds m_data still full.

module fifo_replacement_cache #(
    parameter int CAPACITY = frc_pkg::CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  frc_pkg::frc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output frc_pkg::frc_out_t m_data
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] slot);
        ring_next = (slot == SLOT_W'(CAPACITY - 1)) ? '0 : slot + 1'b1;
    endfunction

    frc_pkg::frc_state_t state_reg, state_next;
    frc_pkg::frc_in_t    req_reg, req_next;
    frc_pkg::frc_out_t   res_reg, res_next;
    frc_pkg::frc_out_t   m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [SLOT_W-1:0]   iss_slot_reg, iss_slot_next;
    logic [SLOT_W-1:0]   cmp_slot_reg, cmp_slot_next;
    logic                pend_reg, pend_next;

    logic [SLOT_W-1:0]   key_raddr;
    logic [SLOT_W-1:0]   value_raddr;
    logic signed [31:0]  key_rdata;
    logic signed [31:0]  value_rdata;
    logic                key_we;
    logic                value_we;
    logic [SLOT_W-1:0]   waddr;
    logic signed [31:0]  key_wdata;
    logic signed [31:0]  value_wdata;
    logic                hit;

    frc_kv_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .aclk        (aclk),
        .key_raddr   (key_raddr),
        .key_rdata   (key_rdata),
        .value_raddr (value_raddr),
        .value_rdata (value_rdata),
        .key_we      (key_we),
        .value_we    (value_we),
        .waddr       (waddr),
        .key_wdata   (key_wdata),
        .value_wdata (value_wdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= frc_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            iss_slot_reg  <= '0;
            cmp_slot_reg  <= '0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            iss_slot_reg  <= iss_slot_next;
            cmp_slot_reg  <= cmp_slot_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // key data arriving this cycle belongs to cmp_slot_reg
    assign hit = pend_reg && (key_rdata == req_reg.key);

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        issue_cnt_next = issue_cnt_reg;
        iss_slot_next  = iss_slot_reg;
        cmp_slot_next  = cmp_slot_reg;
        pend_next      = pend_reg;
        s_ready        = 1'b0;
        key_raddr      = iss_slot_reg;
        value_raddr    = cmp_slot_reg;
        key_we         = 1'b0;
        value_we       = 1'b0;
        waddr          = cmp_slot_reg;
        key_wdata      = req_reg.key;
        value_wdata    = req_reg.write_value;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            frc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next       = s_data;
                    issue_cnt_next = '0;
                    pend_next      = 1'b0;
                    iss_slot_next  = head_reg;
                    state_next     = frc_pkg::ST_SEARCH;
                end
            end
            frc_pkg::ST_SEARCH: begin
                if (hit) begin
                    pend_next = 1'b0;
                    if (req_reg.mode == frc_pkg::MODE_PUT) begin
                        // overwrite in place, order unchanged
                        value_we   = 1'b1;
                        res_next   = '{status: frc_pkg::STATUS_OK, read_value: '0};
                        state_next = frc_pkg::ST_REPLY;
                    end else begin
                        state_next = frc_pkg::ST_VALUE;
                    end
                end else if (issue_cnt_reg < count_reg) begin
                    pend_next      = 1'b1;
                    cmp_slot_next  = iss_slot_reg;
                    iss_slot_next  = ring_next(iss_slot_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (req_reg.mode == frc_pkg::MODE_PUT) begin
                        key_we    = 1'b1;
                        value_we  = 1'b1;
                        waddr     = tail_reg;
                        tail_next = ring_next(tail_reg);
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            head_next = ring_next(head_reg);
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                        res_next = '{status: frc_pkg::STATUS_OK, read_value: '0};
                    end else begin
                        res_next = '{status: frc_pkg::STATUS_MISS, read_value: '0};
                    end
                    state_next = frc_pkg::ST_REPLY;
                end
            end
            frc_pkg::ST_VALUE: begin
                res_next   = '{status: frc_pkg::STATUS_OK, read_value: value_rdata};
                state_next = frc_pkg::ST_REPLY;
            end
            frc_pkg::ST_REPLY: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = frc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = frc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== test/fifo_replacement_cache_tb.sv =====
`timescale 1ns / 1ps

module fifo_replacement_cache_tb;

    localparam int CAPACITY        = frc_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS    = 1080;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 3 * (CAPACITY + 4);

    // Mirror of the ring: head, tail and count plus both stores.
    class cache_tracker;
        logic [31:0]       key_slot [CAPACITY];
        logic [31:0]       value_slot [CAPACITY];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       fill;
        frc_pkg::frc_out_t reply_q[$];
        int unsigned       mismatches;

        function new();
            head       = 0;
            tail       = 0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned ring_step(int unsigned slot);
            return (slot + 1 >= CAPACITY) ? 0 : slot + 1;
        endfunction

        function void note_request(frc_pkg::frc_in_t req);
            frc_pkg::frc_out_t rsp;
            int unsigned       s;
            int unsigned       hit_slot;
            bit                found;
            int unsigned       i;
            found    = 1'b0;
            hit_slot = 0;
            s        = head;
            for (i = 0; i < fill; i++) begin
                if (!found && key_slot[s] == req.key) begin
                    found    = 1'b1;
                    hit_slot = s;
                end
                s = ring_step(s);
            end
            rsp.status     = frc_pkg::STATUS_OK;
            rsp.read_value = '0;
            if (req.mode == frc_pkg::MODE_LOOKUP) begin
                if (found) rsp.read_value = value_slot[hit_slot];
                else       rsp.status     = frc_pkg::STATUS_MISS;
            end else if (found) begin
                value_slot[hit_slot] = req.write_value;
            end else begin
                // full ring: drop the oldest entry before the insert
                if (fill >= CAPACITY) begin
                    head = ring_step(head);
                    fill = CAPACITY - 1;
                end
                key_slot[tail]   = req.key;
                value_slot[tail] = req.write_value;
                tail             = ring_step(tail);
                fill++;
            end
            reply_q.push_back(rsp);
        endfunction

        function void check_reply(frc_pkg::frc_out_t got);
            frc_pkg::frc_out_t want;
            if (reply_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: status %0b value %h", got.status,
                             got.read_value);
                return;
            end
            want = reply_q.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"reply mismatch: expected status %0b value %h, ",
                              "got status %0b value %h"},
                             want.status, want.read_value, got.status, got.read_value);
            end
        endfunction

        function int unsigned pending();
            return reply_q.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    frc_pkg::frc_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    frc_pkg::frc_out_t m_data;

    cache_tracker tracker;
    bit           hold_off_pending;
    int unsigned  burst_left;
    int unsigned  quiet_cycles;
    logic [31:0]  key_pool [32];
    int unsigned  pool_size;

    fifo_replacement_cache #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic frc_pkg::frc_in_t make_req(logic mode, logic [31:0] key,
                                                  logic [31:0] wval);
        frc_pkg::frc_in_t req;
        req.mode        = mode;
        req.key         = key;
        req.write_value = wval;
        return req;
    endfunction

    task automatic send_request(frc_pkg::frc_in_t req);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(req);
    endtask

    // Drives valid low for the given idle count; payload is junk meanwhile
    task automatic idle_cycles(int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_data  <= make_req(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
    endtask

    task automatic offer(frc_pkg::frc_in_t req);
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(10, 40));
            else                           idle_cycles($urandom_range(0, 5));
            burst_left = $urandom_range(1, 24);
        end
        send_request(req);
        burst_left--;
    endtask

    task automatic refill_key_pool();
        pool_size = $urandom_range(6, 32);
        foreach (key_pool[i]) key_pool[i] = $urandom;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // Receiver: random stall patterns in turn, plus one long hold-off
    initial begin
        int unsigned stall_mode;
        int unsigned cyc;
        m_ready    = 1'b0;
        stall_mode = 0;
        cyc        = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else begin
                if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
                cyc++;
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_reply(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned hold_at;
        int unsigned i;
        tracker          = new();
        hold_off_pending = 1'b0;
        burst_left       = 0;
        quiet_cycles     = 0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_data           = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty miss, extreme keys and values, overwrite, eviction
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h1234_5678));
        offer(make_req(frc_pkg::MODE_PUT,    32'h8000_0000, 32'h7FFF_FFFF));
        offer(make_req(frc_pkg::MODE_PUT,    32'h7FFF_FFFF, 32'h8000_0000));
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0));
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        offer(make_req(frc_pkg::MODE_PUT,    32'h8000_0000, 32'hFFFF_FFFF));
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0));
        offer(make_req(frc_pkg::MODE_PUT,    32'h0000_0000, 32'h0000_0000));
        offer(make_req(frc_pkg::MODE_PUT,    32'hFFFF_FFFF, 32'h8000_0000));
        for (i = 0; i < 13; i++)
            offer(make_req(frc_pkg::MODE_PUT, 32'h0101_0101 * (i + 1), $urandom));
        // seventeenth distinct put has pushed out the oldest key
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0));
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0));
        offer(make_req(frc_pkg::MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));

        hold_at = $urandom_range(300, 600);
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 200 == 0) refill_key_pool();
            if (i == hold_at) hold_off_pending = 1'b1;
            offer(make_req(1'($urandom_range(0, 1)), pick_key(), $urandom));
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== fifo_replacement_cache.f =====
sv/frc_pkg.sv
sv/frc_kv_mem.sv
sv/fifo_replacement_cache.sv
test/fifo_replacement_cache_tb.sv
